// ===== design/sbfd_pkg.sv =====
package sbfd_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CH_BITS = 11;
  localparam int unsigned CH_IDX_W = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned DEC_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned FRAME_DEPTH = 25;

  localparam logic [POS_W-1:0] FRAME_LEN      = 5'd25;
  localparam logic [POS_W-1:0] LAST_POS       = 5'd24;
  localparam logic [POS_W-1:0] HEAD_POS       = 5'd0;
  localparam logic [POS_W-1:0] FLAGS_POS      = 5'd23;
  localparam logic [POS_W-1:0] FIRST_DATA_POS = 5'd1;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;

  localparam logic [CH_IDX_W-1:0] CH_LAST = 4'd15;

  // sync modes
  localparam logic SYNC_GAP    = 1'b0;
  localparam logic SYNC_HEADER = 1'b1;

  // result kinds
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_CHANNEL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_EVERY = 2'd2;

  localparam logic [THR_W-1:0] GAP_THRESH_RST   = 16'd2000;
  localparam logic [DEC_W-1:0] DECODE_EVERY_RST = 8'd20;

  typedef struct packed {
    logic                kind;
    logic [CH_IDX_W-1:0] channel_index;
    logic [CH_BITS-1:0]  channel_value;
    logic [BYTE_W-1:0]   frame_flags;
    logic                link_ok;
    logic [COUNT_W-1:0]  frame_count;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [CH_IDX_W-1:0] index;
    logic [CH_BITS-1:0]  value;
  } chan_t;

endpackage

// ===== design/sbfd_ram.sv =====
module sbfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sbfd_unpack.sv =====
module sbfd_unpack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          room,
  input  logic [sbfd_pkg::BYTE_W-1:0]   rd_data,
  output logic [sbfd_pkg::POS_W-1:0]    rd_addr,
  output logic                          busy,
  output sbfd_pkg::chan_t               chan
);
  import sbfd_pkg::*;

  // enough for ten leftover bits plus one new byte
  localparam int unsigned ACC_W = CH_BITS + BYTE_W - 1;
  localparam int unsigned CNT_W = $clog2(ACC_W + 1);

  logic                busy_r, busy_nxt;
  logic                pend_r, pend_nxt;
  logic [POS_W-1:0]    addr_r, addr_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CH_IDX_W-1:0] ch_r, ch_nxt;
  logic                have_ch;
  logic                emit;

  assign have_ch = (cnt_r >= CNT_W'(CH_BITS));
  assign emit    = busy_r && !pend_r && have_ch && room;

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    addr_nxt = addr_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ch_nxt   = ch_r;
    if (start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      addr_nxt = FIRST_DATA_POS;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      ch_nxt   = '0;
    end else if (busy_r) begin
      if (pend_r) begin
        // bits are packed LSB first, so new bytes land above what is left
        acc_nxt  = acc_r | (ACC_W'(rd_data) << cnt_r);
        cnt_nxt  = cnt_r + CNT_W'(BYTE_W);
        pend_nxt = 1'b0;
      end else if (have_ch) begin
        if (room) begin
          acc_nxt = acc_r >> CH_BITS;
          cnt_nxt = cnt_r - CNT_W'(CH_BITS);
          ch_nxt  = ch_r + CH_IDX_W'(1);
          if (ch_r == CH_LAST) begin
            busy_nxt = 1'b0;
          end
        end
      end else begin
        addr_nxt = addr_r + POS_W'(1);
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
    end
    addr_r <= addr_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    ch_r   <= ch_nxt;
  end

  assign rd_addr     = addr_r;
  assign busy        = busy_r;
  assign chan.valid  = emit;
  assign chan.last   = (ch_r == CH_LAST);
  assign chan.index  = ch_r;
  assign chan.value  = acc_r[CH_BITS-1:0];

endmodule

// ===== design/sbfd_outq.sv =====
module sbfd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sbfd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output sbfd_pkg::result_t out_data
);
  import sbfd_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r + 2'(push) - 2'(pop);
    if (pop) begin
      if (cnt_r == 2'd2) begin
        slot0_nxt = slot1_r;
      end else if (push) begin
        slot0_nxt = push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

endmodule

// ===== design/sbus_frame_decoder.sv =====
// SBUS frame decoder. Takes one receiver byte per transaction with its microsecond
// timestamp and builds 25-byte frames, either by inter-byte gap (sync_mode 0, header
// 0x0F required) or by header/footer bytes (sync_mode 1). Each completed frame yields
// one result, except every decode_every-th, which yields sixteen channel results
// (11 bits each) carrying the flags byte, the sticky link-ok bit and the frame count.
// A byte is taken every cycle while input is not held off; a byte that completes an unpacked
// frame holds off input while the unpacker walks bytes 1..22 of the frame memory
// through its single read port, fetching each byte and then emitting each finished channel,
// plus any time the result side stalls. Results leave through a two-entry queue, so bytes
// keep flowing while a finished result waits.
module sbus_frame_decoder #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbfd_pkg::THR_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  input  logic [31:0]                         in_arrival_time_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [3:0]                          out_channel_index,
  output logic [10:0]                         out_channel_value,
  output logic [7:0]                          out_frame_flags,
  output logic                                out_link_ok,
  output logic [15:0]                         out_frame_count,
  output logic                                out_last
);
  import sbfd_pkg::*;

  // configuration
  logic                  mode_r;
  logic [THR_W-1:0]      thr_r;
  logic [DEC_W-1:0]      every_r;

  // framing state
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [TIME_WIDTH-1:0] prev_time_r, prev_time_nxt;
  logic [DEC_W-1:0]      dec_r, dec_nxt;
  logic [COUNT_W-1:0]    frames_r, frames_nxt;
  logic                  link_r, link_nxt;
  logic                  await_r, await_nxt;
  logic [BYTE_W-1:0]     prev_byte_r, prev_byte_nxt;
  logic                  in_frame_r, in_frame_nxt;
  // copies of frame bytes 0 and 23, kept in step with the frame memory
  logic [BYTE_W-1:0]     byte0_r, byte0_nxt;
  logic [BYTE_W-1:0]     flags_r, flags_nxt;

  logic                  in_accept;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] delta;
  logic [POS_W-1:0]      pos_inc;
  logic [POS_W-1:0]      gap_pos;
  logic                  hdr_start;
  logic [POS_W-1:0]      hdr_pos;
  logic                  hdr_open;
  logic [DEC_W-1:0]      dec_inc;

  logic                  wr_en;
  logic [POS_W-1:0]      wr_addr;
  logic                  complete;
  logic                  unpack_go;
  logic                  main_push;

  logic [POS_W-1:0]      rd_addr;
  logic [BYTE_W-1:0]     rd_data;
  logic                  up_busy;
  chan_t                 up_chan;

  logic                  q_push;
  logic                  q_full;
  result_t               q_data;
  result_t               q_out;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = up_busy || q_full;

  assign now       = TIME_WIDTH'(in_arrival_time_us);
  assign delta     = now - prev_time_r;
  assign pos_inc   = pos_r + POS_W'(1);
  assign gap_pos   = (delta > TIME_WIDTH'(thr_r)) ? HEAD_POS : pos_inc;
  assign hdr_start = (in_rx_byte == HEADER_BYTE) && (await_r || prev_byte_r == FOOTER_BYTE);
  assign hdr_pos   = hdr_start ? HEAD_POS : pos_r;
  assign hdr_open  = hdr_start || in_frame_r;
  assign dec_inc   = dec_r + DEC_W'(1);

  always_comb begin
    pos_nxt       = pos_r;
    prev_time_nxt = prev_time_r;
    await_nxt     = await_r;
    prev_byte_nxt = prev_byte_r;
    in_frame_nxt  = in_frame_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    complete      = 1'b0;
    if (in_accept) begin
      if (mode_r == SYNC_GAP) begin
        prev_time_nxt = now;
        if (gap_pos < FRAME_LEN) begin
          wr_en    = 1'b1;
          wr_addr  = gap_pos;
          pos_nxt  = gap_pos;
          complete = (gap_pos == LAST_POS) && (byte0_r == HEADER_BYTE);
        end else begin
          pos_nxt = HEAD_POS;
        end
      end else begin
        prev_byte_nxt = in_rx_byte;
        if (hdr_start) begin
          await_nxt = 1'b0;
        end
        in_frame_nxt = hdr_open;
        pos_nxt      = hdr_pos + POS_W'(1);
        if (hdr_open) begin
          if (hdr_pos < FRAME_LEN) begin
            wr_en   = 1'b1;
            wr_addr = hdr_pos;
            if (hdr_pos == LAST_POS && in_rx_byte == FOOTER_BYTE) begin
              complete     = 1'b1;
              in_frame_nxt = 1'b0;
              pos_nxt      = FIRST_DATA_POS;
            end
          end else begin
            // overran without a footer: drop the frame
            in_frame_nxt = 1'b0;
            pos_nxt      = FIRST_DATA_POS;
          end
        end
      end
    end
  end

  assign unpack_go = complete && !(dec_inc < every_r);
  assign main_push = complete && !unpack_go;

  always_comb begin
    frames_nxt = frames_r;
    dec_nxt    = dec_r;
    link_nxt   = link_r;
    byte0_nxt  = byte0_r;
    flags_nxt  = flags_r;
    if (complete) begin
      frames_nxt = frames_r + COUNT_W'(1);
      dec_nxt    = unpack_go ? '0 : dec_inc;
      if (unpack_go && flags_r == '0) begin
        link_nxt = 1'b1;
      end
    end
    if (wr_en && wr_addr == HEAD_POS) begin
      byte0_nxt = in_rx_byte;
    end
    if (wr_en && wr_addr == FLAGS_POS) begin
      flags_nxt = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= SYNC_GAP;
      thr_r       <= GAP_THRESH_RST;
      every_r     <= DECODE_EVERY_RST;
      pos_r       <= '0;
      prev_time_r <= '0;
      dec_r       <= '0;
      frames_r    <= '0;
      link_r      <= 1'b0;
      await_r     <= 1'b1;
      prev_byte_r <= 8'hFF;
      in_frame_r  <= 1'b0;
      byte0_r     <= '0;
      flags_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_MODE:    mode_r  <= cfg_wdata[0];
          CFG_GAP_THRESH:   thr_r   <= cfg_wdata;
          CFG_DECODE_EVERY: every_r <= cfg_wdata[DEC_W-1:0];
          default: ;
        endcase
      end
      pos_r       <= pos_nxt;
      prev_time_r <= prev_time_nxt;
      dec_r       <= dec_nxt;
      frames_r    <= frames_nxt;
      link_r      <= link_nxt;
      await_r     <= await_nxt;
      prev_byte_r <= prev_byte_nxt;
      in_frame_r  <= in_frame_nxt;
      byte0_r     <= byte0_nxt;
      flags_r     <= flags_nxt;
    end
  end

  sbfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_rx_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sbfd_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unpack_go),
    .room    (!q_full),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .busy    (up_busy),
    .chan    (up_chan)
  );

  // input is held off while unpacking, so the two sources never push together
  always_comb begin
    if (main_push) begin
      q_data.kind          = KIND_FRAME;
      q_data.channel_index = '0;
      q_data.channel_value = '0;
      q_data.frame_flags   = '0;
      q_data.link_ok       = link_r;
      q_data.frame_count   = frames_nxt;
      q_data.last          = 1'b1;
    end else begin
      q_data.kind          = KIND_CHANNEL;
      q_data.channel_index = up_chan.index;
      q_data.channel_value = up_chan.value;
      q_data.frame_flags   = flags_r;
      q_data.link_ok       = link_r;
      q_data.frame_count   = frames_r;
      q_data.last          = up_chan.last;
    end
  end

  assign q_push = main_push || up_chan.valid;

  sbfd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_out)
  );

  assign out_kind          = q_out.kind;
  assign out_channel_index = q_out.channel_index;
  assign out_channel_value = q_out.channel_value;
  assign out_frame_flags   = q_out.frame_flags;
  assign out_link_ok       = q_out.link_ok;
  assign out_frame_count   = q_out.frame_count;
  assign out_last          = q_out.last;

  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n) !(main_push && up_chan.valid))
    else $error("frame result and channel result pushed together");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CHANNEL) |-> (out_last == (out_channel_index == CH_LAST)))
    else $error("last flag out of step with channel index");

  assert property (@(posedge clk) disable iff (!rst_n)
    unpack_go |=> (up_busy && in_stall))
    else $error("input not held off at start of unpack");

endmodule
